FILE: rtl/alhi_pkg.sv
package alhi_pkg;
  localparam int unsigned CoordW = 32;
  localparam int unsigned LenW = 40;
  localparam int unsigned RatioW = 17;
  localparam int unsigned SqW = 66;
  localparam int unsigned RootW = 33;
  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};
endpackage

FILE: rtl/alhi_ram.sv
module alhi_ram #(
  parameter int unsigned Width = 40,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/arc_length_height_interpolator_unit.sv
// loading: a stored point after the first keeps the input stalled through two
// shift-add squares, a 33-step square root and an accumulate step
// emission: each inner point takes a RAM read, a 57-step restoring divider, a
// bit-serial multiply and the output handshake; first and last skip the arithmetic
// handshake: one item at a time; a first point is taken without stalling the input
// reset: synchronous, clears the point count, held heights and previous point
module arc_length_height_interpolator_unit #(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            x,
  input  logic signed [31:0]            y,
  input  logic signed [31:0]            start_z,
  input  logic signed [31:0]            goal_z,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [5:0]                    point_index,
  output logic signed [31:0]            z,
  output logic                          last_out
);
  import alhi_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_ROOT, S_ACC, S_ERD, S_EWAIT, S_DIV, S_MUL, S_OUT
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [31:0] prev_x, prev_y, hs_z, ht_z;
  logic pend_last;

  logic [31:0] dx, dy, mcand;
  logic [5:0]  bitcnt;
  logic [SqW-1:0] sq, prod;
  logic [SqW-1:0] rad;
  logic [RootW+1:0] rem;
  logic [RootW-1:0] root;
  logic [LenW-1:0] acc_prev, total;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [LenW-1:0] wdata, rdata;

  logic [AW-1:0] idx;
  logic [LenW+16:0] dnum;
  logic [LenW:0] drem;
  logic [LenW-1:0] dden;
  logic [RatioW-1:0] quo;
  logic signed [33:0] diff;
  logic signed [51:0] mprod;
  logic [RatioW-1:0] mq;

  alhi_ram #(.Width(LenW), .Depth(MAX_POINTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [32:0] xd, yd;
  assign xd = 33'($signed(x)) - 33'($signed(prev_x));
  assign yd = 33'($signed(y)) - 33'($signed(prev_y));

  logic [RootW+1:0] trial;
  assign trial = {rem[RootW-1:0], rad[SqW-1 -: 2]} - {root, 2'b01};
  logic [LenW:0] dtry;
  assign dtry = {drem[LenW-1:0], dnum[LenW+16]} - {1'b0, dden};
  logic [LenW:0] sum;
  assign sum = {1'b0, acc_prev} + {{(LenW-RootW+1){1'b0}}, root};

  assign in_stall = (state != S_IDLE);

  always_comb begin
    we = 1'b0;
    waddr = count[AW-1:0];
    wdata = sum[LenW] ? LenMax : sum[LenW-1:0];
    raddr = idx;
    if (state == S_ACC) we = 1'b1;
    if (state == S_IDLE && in_valid && count == '0) begin
      we = 1'b1;
      waddr = '0;
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      prev_x <= '0;
      prev_y <= '0;
      hs_z <= '0;
      ht_z <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pend_last <= last;
            if (count == '0) begin
              hs_z <= start_z;
              ht_z <= goal_z;
              prev_x <= x;
              prev_y <= y;
              acc_prev <= '0;
              count <= CW'(1);
              total <= '0;
              idx <= '0;
              state <= last ? S_ERD : S_IDLE;
            end else if (count < CW'(MAX_POINTS)) begin
              dx <= xd[32] ? 32'(-xd) : xd[31:0];
              dy <= yd[32] ? 32'(-yd) : yd[31:0];
              mcand <= xd[32] ? 32'(-xd) : xd[31:0];
              prev_x <= x;
              prev_y <= y;
              prod <= '0;
              bitcnt <= '0;
              state <= S_SQX;
            end else begin
              idx <= '0;
              state <= last ? S_ERD : S_IDLE;
            end
          end
        end
        S_SQX, S_SQY: begin
          if (bitcnt != 6'd31) begin
            if (mcand[0]) prod <= prod + (SqW'(dx) << bitcnt);
            mcand <= mcand >> 1;
            bitcnt <= bitcnt + 1'b1;
          end else begin
            bitcnt <= '0;
            if (state == S_SQX) begin
              sq <= prod + (mcand[0] ? (SqW'(dx) << bitcnt) : '0);
              prod <= '0;
              mcand <= dy;
              dx <= dy;
              state <= S_SQY;
            end else begin
              rad <= sq + prod + (mcand[0] ? (SqW'(dx) << bitcnt) : '0);
              rem <= '0;
              root <= '0;
              state <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          rad <= rad << 2;
          if (!trial[RootW+1]) begin
            rem <= trial;
            root <= {root[RootW-2:0], 1'b1};
          end else begin
            rem <= {rem[RootW-1:0], rad[SqW-1 -: 2]};
            root <= {root[RootW-2:0], 1'b0};
          end
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == 6'd32) state <= S_ACC;
        end
        S_ACC: begin
          count <= count + 1'b1;
          acc_prev <= wdata;
          idx <= '0;
          state <= pend_last ? S_ERD : S_IDLE;
        end
        S_ERD: begin
          if (idx == '0) total <= acc_prev;
          state <= S_EWAIT;
        end
        S_EWAIT: begin
          if (idx == '0) begin
            quo <= '0;
            state <= S_OUT;
            z <= hs_z;
          end else if (idx == AW'(count - 1'b1)) begin
            z <= ht_z;
            state <= S_OUT;
          end else begin
            if (total != '0) begin
              dnum <= {1'b0, rdata, 16'd0};
              dden <= total;
            end else begin
              dnum <= (LenW+17)'({idx, 16'd0});
              dden <= LenW'(count - 1'b1);
            end
            drem <= '0;
            quo <= '0;
            bitcnt <= '0;
            state <= S_DIV;
          end
          point_index <= 6'(idx);
          last_out <= (idx == AW'(count - 1'b1));
          diff <= 34'($signed(ht_z)) - 34'($signed(hs_z));
        end
        S_DIV: begin
          dnum <= dnum << 1;
          if (!dtry[LenW]) begin
            drem <= dtry;
            quo <= {quo[RatioW-2:0], 1'b1};
          end else begin
            drem <= {drem[LenW-1:0], dnum[LenW+16]};
            quo <= {quo[RatioW-2:0], 1'b0};
          end
          if (bitcnt == 6'(LenW + 16)) begin
            mprod <= '0;
            bitcnt <= '0;
            state <= S_MUL;
          end else begin
            bitcnt <= bitcnt + 1'b1;
          end
        end
        S_MUL: begin
          if (bitcnt == '0) mq <= quo;
          else begin
            if (mq[0]) mprod <= mprod + (52'(diff) <<< (bitcnt - 1'b1));
            mq <= mq >> 1;
          end
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == 6'(RatioW)) begin
            state <= S_OUT;
            z <= 32'($signed(hs_z) + ((mprod + (mq[0] ?
              (52'(diff) <<< (bitcnt - 1'b1)) : '0)) >>> 16));
          end
        end
        S_OUT: begin
          if (!out_valid) out_valid <= 1'b1;
          else if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_out) begin
              count <= '0;
              state <= S_IDLE;
            end else begin
              idx <= idx + 1'b1;
              state <= S_ERD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_stall_busy;
    @(posedge clk) disable iff (rst) out_valid |-> in_stall;
  endproperty
  a_stall_busy: assert property (p_stall_busy) else $error("input taken during emission");

  property p_hold;
    @(posedge clk) disable iff (rst) out_valid && out_stall |=> out_valid && $stable(z);
  endproperty
  a_hold: assert property (p_hold) else $error("result dropped");

  property p_count;
    @(posedge clk) disable iff (rst) count <= CW'(MAX_POINTS);
  endproperty
  a_count: assert property (p_count) else $error("point count overflow");
endmodule
